FILE: design/bpip_pkg.sv
// bpip_pkg: shared constants, types and state encoding for the banded
// point-in-polygon core. No dependencies.
`timescale 1ns / 1ps
package bpip_pkg;

    localparam int MAX_EDGES  = 1024;
    localparam int BAND_LIMIT = 64;
    localparam int EDGE_AW    = $clog2(MAX_EDGES);
    localparam int TOTAL_W    = EDGE_AW + 1;
    localparam int BAND_W     = $clog2(BAND_LIMIT);
    localparam int NCNT_W     = BAND_W + 1;
    localparam int REM_W      = 32 + BAND_W;
    localparam int STEP_W     = (BAND_W > 1) ? $clog2(BAND_W) : 1;

    // item function codes
    localparam logic [1:0] FN_CLEAR = 2'd0;
    localparam logic [1:0] FN_LOAD  = 2'd1;
    localparam logic [1:0] FN_QUERY = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_LOW_Y  = 2'd0;
    localparam logic [1:0] CFG_HIGH_Y = 2'd1;
    localparam logic [1:0] CFG_BANDS  = 2'd2;

    typedef struct packed {
        logic signed [31:0] ax;
        logic signed [30:0] ay;
        logic signed [31:0] bx;
        logic signed [30:0] by;
        logic [BAND_W-1:0]  first;
        logic [BAND_W-1:0]  last;
    } edge_t;

    localparam int EDGE_BITS = $bits(edge_t);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LO_START,
        ST_LO_WAIT,
        ST_HI_START,
        ST_HI_WAIT,
        ST_WRITE,
        ST_QB_START,
        ST_QB_WAIT,
        ST_FETCH,
        ST_EVAL_DIFF,
        ST_EVAL_MUL,
        ST_EVAL_ACC,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic latch;
        logic total_clr;
        logic band_start;
        logic band_sel;
        logic store_first;
        logic ram_we;
        logic walk_clr;
        logic edge_rd;
        logic eval_diff;
        logic eval_mul;
        logic eval_acc;
        logic set_full;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic band_busy;
        logic total_full;
        logic more_edges;
        logic hit;
        logic out_free;
    } status_t;

endpackage

FILE: design/banded_point_in_polygon_core.sv
// banded_point_in_polygon_core: top level joining controller and datapath.
// Depends on bpip_pkg, bpip_ctrl, bpip_datapath (and bpip_ram below it).
`timescale 1ns / 1ps
// usage
// - s_ channel carries one item: tuser is the function (clear, load, query),
//   tdata the coordinates; m_ channel returns one result item per input item
// - config writes (cfg_wr_en/cfg_index/cfg_wdata) set envelope low y,
//   envelope high y and band count; write only while the block is idle
// - one item at a time: s_tready is high only while the controller waits
// - clear and unused codes: the controller goes from idle straight to its
//   done state, which loads the result register, then takes the next item
// - load: two band divisions, each trivial or BAND_W quotient bits at
//   one quotient bit per cycle, then a store write
// - query: one band division, then for each stored edge a ram read,
//   differences, cross products and a parity update, until the list ends
//   or a boundary hit
// - a load with the store full skips the write and flags store_full
// - reset clears the edge count, config to defaults and the output valid;
//   the edge memory itself is not cleared
// - if m_tready is low the result holds in the output register and the
//   controller waits in its done state before taking the next item
module banded_point_in_polygon_core (
    input  logic         aclk,
    input  logic         aresetn,
    // configuration write port
    input  logic         cfg_wr_en,
    input  logic [1:0]   cfg_index,
    input  logic [30:0]  cfg_wdata,
    // input items
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,  // coord_ax[31:0], coord_ay, coord_bx, coord_by, pad
    input  logic [1:0]   s_tuser,  // func
    // result items
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [7:0]   m_tdata   // inside_res, on_boundary, store_full, pad
);

    bpip_pkg::cmd_t    cmd;
    bpip_pkg::status_t status;

    // sequencing
    bpip_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tuser (s_tuser),
        .s_tready(s_tready),
        .status  (status),
        .cmd     (cmd)
    );

    // storage and arithmetic
    bpip_datapath u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .cmd      (cmd),
        .status   (status),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

FILE: design/bpip_ram.sv
// bpip_ram: generic single-port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module bpip_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

FILE: design/bpip_datapath.sv
// bpip_datapath: config registers, band divider, edge store, crossing test
// and output register. Depends on bpip_pkg and bpip_ram.
`timescale 1ns / 1ps
module bpip_datapath (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [1:0]             cfg_index,
    input  logic [30:0]            cfg_wdata,
    input  logic [127:0]           s_tdata,
    input  logic [1:0]             s_tuser,
    input  bpip_pkg::cmd_t         cmd,
    output bpip_pkg::status_t      status,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [7:0]             m_tdata
);

    // configuration
    logic signed [30:0] low_reg, high_reg;
    logic [6:0]         bands_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            low_reg   <= '0;
            high_reg  <= '0;
            bands_reg <= 7'd1;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                bpip_pkg::CFG_LOW_Y:  low_reg   <= cfg_wdata;
                bpip_pkg::CFG_HIGH_Y: high_reg  <= cfg_wdata;
                bpip_pkg::CFG_BANDS:  bands_reg <= cfg_wdata[6:0];
                default: ;
            endcase
        end
    end

    logic [bpip_pkg::NCNT_W-1:0] n_eff;
    always_comb begin
        if (bands_reg == 7'd0) begin
            n_eff = bpip_pkg::NCNT_W'(1);
        end else if (32'(bands_reg) > bpip_pkg::BAND_LIMIT) begin
            n_eff = bpip_pkg::NCNT_W'(bpip_pkg::BAND_LIMIT);
        end else begin
            n_eff = bpip_pkg::NCNT_W'(bands_reg);
        end
    end

    // latched item
    logic [1:0]         func_reg;
    logic signed [31:0] ax_reg, bx_reg;
    logic signed [30:0] ay_reg, by_reg;

    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            func_reg <= s_tuser;
            ax_reg   <= s_tdata[31:0];
            ay_reg   <= s_tdata[62:32];
            bx_reg   <= s_tdata[94:63];
            by_reg   <= s_tdata[125:95];
        end
    end

    // band divider: floor((y - low) * n / h) in 0..n-1 (0 if h <= 0), one quotient bit a cycle
    logic signed [30:0] y_lo, y_hi, y_sel;
    logic signed [31:0] h_w, d_w;
    logic [bpip_pkg::REM_W-1:0]  h_u, h_sh, rem_reg, rem_next;
    logic [bpip_pkg::BAND_W-1:0] q_reg, q_next, first_reg;
    logic [bpip_pkg::STEP_W-1:0] step_reg, step_next;
    logic                        busy_reg, busy_next;

    always_comb begin
        if (func_reg == bpip_pkg::FN_QUERY) begin
            y_lo = ay_reg;
        end else begin
            y_lo = (ay_reg < by_reg) ? ay_reg : by_reg;
        end
        y_hi  = (ay_reg < by_reg) ? by_reg : ay_reg;
        y_sel = cmd.band_sel ? y_hi : y_lo;
        h_w   = 32'(high_reg) - 32'(low_reg);
        d_w   = 32'(y_sel) - 32'(low_reg);
        h_u   = bpip_pkg::REM_W'(h_w[30:0]);
        h_sh  = h_u << step_reg;

        rem_next  = rem_reg;
        q_next    = q_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        if (cmd.band_start) begin
            q_next    = '0;
            busy_next = 1'b0;
            if (h_w <= 0 || d_w < 0) begin
                q_next = '0;
            end else if (d_w >= h_w) begin
                q_next = bpip_pkg::BAND_W'(n_eff - 1'b1);
            end else begin
                rem_next  = bpip_pkg::REM_W'(d_w[30:0]) * bpip_pkg::REM_W'(n_eff);
                step_next = bpip_pkg::STEP_W'(bpip_pkg::BAND_W - 1);
                busy_next = 1'b1;
            end
        end else if (busy_reg) begin
            if (rem_reg >= h_sh) begin
                rem_next         = rem_reg - h_sh;
                q_next[step_reg] = 1'b1;
            end
            if (step_reg == '0) begin
                busy_next = 1'b0;
            end else begin
                step_next = step_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
        end
        rem_reg  <= rem_next;
        q_reg    <= q_next;
        step_reg <= step_next;
        if (cmd.store_first) begin
            first_reg <= q_reg;
        end
    end

    // edge store
    logic [bpip_pkg::TOTAL_W-1:0] total_reg, idx_reg;
    bpip_pkg::edge_t               wr_edge, rd_edge;
    logic [bpip_pkg::EDGE_AW-1:0] ram_addr;
    logic [bpip_pkg::EDGE_BITS-1:0] ram_rdata;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_reg <= '0;
        end else if (cmd.total_clr) begin
            total_reg <= '0;
        end else if (cmd.ram_we) begin
            total_reg <= total_reg + 1'b1;
        end
        if (cmd.walk_clr) begin
            idx_reg <= '0;
        end else if (cmd.edge_rd) begin
            idx_reg <= idx_reg + 1'b1;
        end
    end

    always_comb begin
        wr_edge.ax    = ax_reg;
        wr_edge.ay    = ay_reg;
        wr_edge.bx    = bx_reg;
        wr_edge.by    = by_reg;
        wr_edge.first = first_reg;
        wr_edge.last  = q_reg;
        ram_addr = cmd.ram_we ? total_reg[bpip_pkg::EDGE_AW-1:0]
                              : idx_reg[bpip_pkg::EDGE_AW-1:0];
        rd_edge  = ram_rdata;
    end

    bpip_ram #(
        .WIDTH(bpip_pkg::EDGE_BITS),
        .DEPTH(bpip_pkg::MAX_EDGES)
    ) u_edge_ram (
        .aclk (aclk),
        .we   (cmd.ram_we),
        .addr (ram_addr),
        .wdata(wr_edge),
        .rdata(ram_rdata)
    );

    // crossing test
    logic signed [32:0] dx_reg, px_reg;
    logic signed [31:0] dy_reg, py_reg;
    logic signed [64:0] p1_reg, p2_reg;
    logic inband_reg, horiz_reg, hhit_reg, strad_reg, dypos_reg;
    logic hit_reg, parity_reg, full_reg;

    always_ff @(posedge aclk) begin
        if (cmd.eval_diff) begin
            inband_reg <= !(q_reg < rd_edge.first || q_reg > rd_edge.last);
            horiz_reg  <= rd_edge.by == rd_edge.ay;
            hhit_reg   <= rd_edge.by == ay_reg &&
                          (rd_edge.ax == ax_reg ||
                           ((rd_edge.bx > ax_reg) != (rd_edge.ax > ax_reg)));
            strad_reg  <= (rd_edge.by > ay_reg) != (rd_edge.ay > ay_reg);
            dypos_reg  <= rd_edge.by > rd_edge.ay;
            dx_reg     <= 33'(rd_edge.bx) - 33'(rd_edge.ax);
            dy_reg     <= 32'(rd_edge.by) - 32'(rd_edge.ay);
            px_reg     <= 33'(ax_reg) - 33'(rd_edge.ax);
            py_reg     <= 32'(ay_reg) - 32'(rd_edge.ay);
        end
        if (cmd.eval_mul) begin
            p1_reg <= px_reg * dy_reg;
            p2_reg <= dx_reg * py_reg;
        end
    end

    // full flag is decided when the item is taken
    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            hit_reg    <= 1'b0;
            parity_reg <= 1'b0;
            full_reg   <= cmd.set_full;
        end else if (cmd.eval_acc && inband_reg) begin
            if (horiz_reg) begin
                if (hhit_reg) begin
                    hit_reg <= 1'b1;
                end
            end else if (strad_reg) begin
                if (p1_reg == p2_reg) begin
                    hit_reg <= 1'b1;
                end else if (dypos_reg == (p1_reg > p2_reg)) begin
                    parity_reg <= !parity_reg;
                end
            end
        end
    end

    // output register
    logic m_tvalid_reg;
    logic [2:0] res_reg;
    logic out_free;

    assign out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
        if (cmd.out_load) begin
            if (func_reg == bpip_pkg::FN_QUERY) begin
                res_reg <= {1'b0, hit_reg, hit_reg | parity_reg};
            end else if (func_reg == bpip_pkg::FN_LOAD) begin
                res_reg <= {full_reg, 2'b00};
            end else begin
                res_reg <= 3'b000;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {5'b0, res_reg};

    always_comb begin
        status.band_busy  = busy_reg;
        status.total_full = total_reg == bpip_pkg::TOTAL_W'(bpip_pkg::MAX_EDGES);
        status.more_edges = idx_reg < total_reg;
        status.hit        = hit_reg;
        status.out_free   = out_free;
    end

endmodule

FILE: design/bpip_ctrl.sv
// bpip_ctrl: controller state machine sequencing loads, band divisions
// and the edge walk. Depends on bpip_pkg.
`timescale 1ns / 1ps
module bpip_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    input  logic [1:0]        s_tuser,
    output logic              s_tready,
    input  bpip_pkg::status_t status,
    output bpip_pkg::cmd_t    cmd
);

    bpip_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= bpip_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            bpip_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    case (s_tuser)
                        bpip_pkg::FN_LOAD:
                            state_next = status.total_full ? bpip_pkg::ST_DONE
                                                           : bpip_pkg::ST_LO_START;
                        bpip_pkg::FN_QUERY: state_next = bpip_pkg::ST_QB_START;
                        default:            state_next = bpip_pkg::ST_DONE;
                    endcase
                end
            end
            bpip_pkg::ST_LO_START: state_next = bpip_pkg::ST_LO_WAIT;
            bpip_pkg::ST_LO_WAIT:
                if (!status.band_busy) state_next = bpip_pkg::ST_HI_START;
            bpip_pkg::ST_HI_START: state_next = bpip_pkg::ST_HI_WAIT;
            bpip_pkg::ST_HI_WAIT:
                if (!status.band_busy) state_next = bpip_pkg::ST_WRITE;
            bpip_pkg::ST_WRITE:    state_next = bpip_pkg::ST_DONE;
            bpip_pkg::ST_QB_START: state_next = bpip_pkg::ST_QB_WAIT;
            bpip_pkg::ST_QB_WAIT:
                if (!status.band_busy) state_next = bpip_pkg::ST_FETCH;
            bpip_pkg::ST_FETCH:
                state_next = (status.hit || !status.more_edges) ? bpip_pkg::ST_DONE
                                                                : bpip_pkg::ST_EVAL_DIFF;
            bpip_pkg::ST_EVAL_DIFF: state_next = bpip_pkg::ST_EVAL_MUL;
            bpip_pkg::ST_EVAL_MUL:  state_next = bpip_pkg::ST_EVAL_ACC;
            bpip_pkg::ST_EVAL_ACC:  state_next = bpip_pkg::ST_FETCH;
            bpip_pkg::ST_DONE:
                if (status.out_free) state_next = bpip_pkg::ST_IDLE;
            default: state_next = bpip_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            bpip_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.latch     = 1'b1;
                    cmd.total_clr = s_tuser == bpip_pkg::FN_CLEAR;
                    cmd.set_full  = s_tuser == bpip_pkg::FN_LOAD && status.total_full;
                end
            end
            bpip_pkg::ST_LO_START: cmd.band_start = 1'b1;
            bpip_pkg::ST_LO_WAIT:  cmd.store_first = !status.band_busy;
            bpip_pkg::ST_HI_START: begin
                cmd.band_start = 1'b1;
                cmd.band_sel   = 1'b1;
            end
            bpip_pkg::ST_HI_WAIT:  ;
            bpip_pkg::ST_WRITE:    cmd.ram_we = 1'b1;
            bpip_pkg::ST_QB_START: begin
                cmd.band_start = 1'b1;
                cmd.walk_clr   = 1'b1;
            end
            bpip_pkg::ST_QB_WAIT:  ;
            bpip_pkg::ST_FETCH:
                cmd.edge_rd = !status.hit && status.more_edges;
            bpip_pkg::ST_EVAL_DIFF: cmd.eval_diff = 1'b1;
            bpip_pkg::ST_EVAL_MUL:  cmd.eval_mul = 1'b1;
            bpip_pkg::ST_EVAL_ACC:  cmd.eval_acc = 1'b1;
            bpip_pkg::ST_DONE:      cmd.out_load = status.out_free;
            default: ;
        endcase
    end

endmodule

FILE: sim/tb_banded_point_in_polygon_core.sv
// tb_banded_point_in_polygon_core: self-checking bench for the banded
// point-in-polygon core. Depends on bpip_pkg and banded_point_in_polygon_core.
`timescale 1ns / 1ps
module tb_banded_point_in_polygon_core;

    // func code the core leaves unused, answers all zero
    localparam logic [1:0] FN_UNUSED = 2'd3;
    localparam int IDLE_LIMIT = 40000;
    localparam int LONG_HOLD  = 400;
    localparam int RANGE_X    = 1800000000;
    localparam int RANGE_Y    = 900000000;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         cfg_wr_en = 1'b0;
    logic [1:0]   cfg_index = bpip_pkg::CFG_LOW_Y;
    logic [30:0]  cfg_wdata = '0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [127:0] s_tdata = '0;
    logic [1:0]   s_tuser = bpip_pkg::FN_CLEAR;
    logic         m_tvalid;
    logic         m_tready = 1'b1;
    logic [7:0]   m_tdata;

    banded_point_in_polygon_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always #5 aclk = ~aclk;

    // predictor copy of the configuration and the edge store
    longint env_lo = 0;
    longint env_hi = 0;
    int     band_reg = 1;
    longint e_ax [bpip_pkg::MAX_EDGES];
    longint e_ay [bpip_pkg::MAX_EDGES];
    longint e_bx [bpip_pkg::MAX_EDGES];
    longint e_by [bpip_pkg::MAX_EDGES];
    int     e_first [bpip_pkg::MAX_EDGES];
    int     e_last [bpip_pkg::MAX_EDGES];
    int     edge_cnt = 0;

    // expected {store_full, on_boundary, inside_res}, oldest first
    logic [2:0] pending_answers[$];
    int  errors = 0;
    bit  quiet = 1'b0;      // no idling on either side
    bit  long_hold = 1'b0;  // ask the receiver for one long stall

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------
    function automatic int band_index(longint y);
        int     n;
        longint h;
        longint num;
        longint b;
        n = (band_reg == 0) ? 1 : ((band_reg > bpip_pkg::BAND_LIMIT) ? bpip_pkg::BAND_LIMIT
                                                                      : band_reg);
        h = env_hi - env_lo;
        if (h <= 0) return 0;
        num = (y - env_lo) * n;
        if (num < 0) return 0;
        b = num / h;
        if (b > n - 1) b = n - 1;
        return int'(b);
    endfunction

    // applies one item to the store copy, returns the answer it causes
    function automatic logic [2:0] polygon_answer(logic [1:0] fn, longint ax, longint ay,
                                                  longint bx, longint by);
        int     band;
        bit     parity;
        bit     hit;
        longint fx, fy, tx, ty, dx, dy, px, py, p1, p2;
        parity = 1'b0;
        hit = 1'b0;
        case (fn)
            bpip_pkg::FN_CLEAR: edge_cnt = 0;
            bpip_pkg::FN_LOAD: begin
                if (edge_cnt >= bpip_pkg::MAX_EDGES) return 3'b100;
                e_ax[edge_cnt] = ax;
                e_ay[edge_cnt] = ay;
                e_bx[edge_cnt] = bx;
                e_by[edge_cnt] = by;
                e_first[edge_cnt] = band_index((ay < by) ? ay : by);
                e_last[edge_cnt] = band_index((ay < by) ? by : ay);
                edge_cnt++;
            end
            bpip_pkg::FN_QUERY: begin
                band = band_index(ay);
                for (int i = 0; i < edge_cnt && !hit; i++) begin
                    if (band < e_first[i] || band > e_last[i]) continue;
                    fx = e_ax[i]; fy = e_ay[i]; tx = e_bx[i]; ty = e_by[i];
                    if (ty == fy) begin
                        // horizontal edge: only a boundary touch counts
                        if (ty == ay && (fx == ax || ((tx > ax) != (fx > ax)))) hit = 1'b1;
                        continue;
                    end
                    if ((ty > ay) != (fy > ay)) begin
                        dx = tx - fx; dy = ty - fy;
                        px = ax - fx; py = ay - fy;
                        p1 = px * dy;
                        p2 = dx * py;
                        if (p1 == p2) hit = 1'b1;
                        else if ((dy > 0) == (p1 > p2)) parity = ~parity;
                    end
                end
                if (hit) return 3'b011;
                return {2'b00, parity};
            end
            default: ;
        endcase
        return 3'b000;
    endfunction

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------
    task automatic send_item(logic [1:0] fn, longint ax, longint ay, longint bx, longint by);
        logic [31:0] ax_w, bx_w;
        logic [30:0] ay_w, by_w;
        logic [2:0]  ans;
        ax_w = ax[31:0]; bx_w = bx[31:0];
        ay_w = ay[30:0]; by_w = by[30:0];
        if (!quiet && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge aclk);
        end
        s_tuser  <= fn;
        s_tdata  <= {2'b00, by_w, bx_w, ay_w, ax_w};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        ans = polygon_answer(fn, ax, ay, bx, by);
        pending_answers = {pending_answers, ans};
        @(negedge aclk);
    endtask

    // stop offering and wait for every answer
    task automatic drain;
        s_tvalid <= 1'b0;
        wait (pending_answers.size() == 0);
        repeat (8) @(negedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, longint value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value[30:0];
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            bpip_pkg::CFG_LOW_Y:  env_lo = value;
            bpip_pkg::CFG_HIGH_Y: env_hi = value;
            default:              band_reg = int'(value) & 8'h7f;
        endcase
    endtask

    task automatic set_config(longint lo, longint hi, int n);
        drain();
        write_reg(bpip_pkg::CFG_LOW_Y, lo);
        write_reg(bpip_pkg::CFG_HIGH_Y, hi);
        write_reg(bpip_pkg::CFG_BANDS, n);
    endtask

    function automatic longint rand_x();
        return longint'($urandom_range(0, 2 * RANGE_X)) - RANGE_X;
    endfunction

    function automatic longint rand_y();
        return longint'($urandom_range(0, 2 * RANGE_Y)) - RANGE_Y;
    endfunction

    // ------------------------------------------------------------------
    // result checker and receiver
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        logic [2:0] want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_answers.size() == 0) begin
                errors++;
                $display("%0t: unexpected result item, expected none actual %b", $time,
                         m_tdata[2:0]);
            end else begin
                want = pending_answers.pop_front();
                if (m_tdata[0] !== want[0]) begin
                    errors++;
                    $display("%0t: inside_res expected %b actual %b",
                             $time, want[0], m_tdata[0]);
                end
                if (m_tdata[1] !== want[1]) begin
                    errors++;
                    $display("%0t: on_boundary expected %b actual %b",
                             $time, want[1], m_tdata[1]);
                end
                if (m_tdata[2] !== want[2]) begin
                    errors++;
                    $display("%0t: store_full expected %b actual %b",
                             $time, want[2], m_tdata[2]);
                end
            end
        end
    end

    // random stalls in bursts, plus one long hold when asked
    initial begin
        forever begin
            @(negedge aclk);
            if (long_hold) begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(negedge aclk);
                m_tready <= 1'b1;
                long_hold = 1'b0;
            end else if (!quiet && $urandom_range(0, 6) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(negedge aclk);
                m_tready <= 1'b1;
            end
        end
    end

    // watchdog on cycles with no handshake
    int idle_cycles = 0;
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == IDLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // square in a four band envelope: inside, outside, vertex, edges, clamping
    task automatic test_square;
        set_config(-1000, 1000, 4);
        send_item(bpip_pkg::FN_CLEAR, 0, 0, 0, 0);
        send_item(bpip_pkg::FN_QUERY, 0, 0, 0, 0);                  // empty store
        send_item(bpip_pkg::FN_LOAD, -500, -500, 500, -500);
        send_item(bpip_pkg::FN_LOAD, 500, -500, 500, 500);
        send_item(bpip_pkg::FN_LOAD, 500, 500, -500, 500);
        send_item(bpip_pkg::FN_LOAD, -500, 500, -500, -500);
        send_item(bpip_pkg::FN_QUERY, 0, 0, 0, 0);                  // center
        send_item(bpip_pkg::FN_QUERY, 600, 0, 0, 0);                // right of it
        send_item(bpip_pkg::FN_QUERY, -600, 100, 0, 0);             // left of it
        send_item(bpip_pkg::FN_QUERY, 500, 500, 0, 0);              // vertex
        send_item(bpip_pkg::FN_QUERY, 100, -500, 0, 0);             // on horizontal edge
        send_item(bpip_pkg::FN_QUERY, -500, 200, 0, 0);             // on vertical edge
        send_item(bpip_pkg::FN_QUERY, 0, 1500, 0, 0);               // above envelope
        send_item(bpip_pkg::FN_QUERY, 0, -1500, 0, 0);              // below envelope
        send_item(bpip_pkg::FN_QUERY, RANGE_X, RANGE_Y, -RANGE_X, -RANGE_Y);
        send_item(bpip_pkg::FN_QUERY, -RANGE_X, -RANGE_Y, RANGE_X, RANGE_Y);
        send_item(FN_UNUSED, -1, -1, -1, -1);
        send_item(bpip_pkg::FN_LOAD, -RANGE_X, -RANGE_Y, RANGE_X, RANGE_Y);  // diagonal
        send_item(bpip_pkg::FN_QUERY, 0, 0, 0, 0);                  // on the diagonal
        send_item(bpip_pkg::FN_QUERY, 1, 0, 0, 0);
        send_item(bpip_pkg::FN_CLEAR, 0, 0, 0, 0);
        send_item(bpip_pkg::FN_QUERY, 0, 0, 0, 0);
    endtask

    // one closed polygon with k vertices, then q queries; grid mode makes
    // vertices and points share a lattice so boundary hits are common
    task automatic random_polygon(int k, int q);
        longint vx[32], vy[32];
        longint sy, qx, qy, lo_y;
        bit     grid;
        int     j;
        grid = ($urandom_range(0, 1) == 1);
        sy = (env_hi > env_lo) ? (env_hi - env_lo) / 8 : 10000000;
        if (sy == 0) sy = 1;
        lo_y = (env_hi > env_lo) ? env_lo : -4 * sy;
        for (int i = 0; i < k; i++) begin
            if (grid) begin
                vx[i] = -400000000 + 100000000 * longint'($urandom_range(0, 8));
                vy[i] = lo_y + sy * longint'($urandom_range(0, 8));
            end else begin
                vx[i] = rand_x();
                vy[i] = rand_y();
            end
        end
        send_item(bpip_pkg::FN_CLEAR, 0, 0, 0, 0);
        for (int i = 0; i < k; i++)
            send_item(bpip_pkg::FN_LOAD, vx[i], vy[i], vx[(i + 1) % k], vy[(i + 1) % k]);
        for (int i = 0; i < q; i++) begin
            j = $urandom_range(0, k - 1);
            case ($urandom_range(0, 5))
                0: begin qx = vx[j]; qy = vy[j]; end
                1: begin
                    // midpoint of an edge, exact when the sums are even
                    qx = (vx[j] + vx[(j + 1) % k]) / 2;
                    qy = (vy[j] + vy[(j + 1) % k]) / 2;
                end
                2: begin qx = rand_x(); qy = rand_y(); end
                default: begin
                    if (grid) begin
                        qx = -450000000 + 50000000 * longint'($urandom_range(0, 18));
                        qy = lo_y + (sy / 2) * longint'($urandom_range(0, 18));
                    end else begin
                        qx = (vx[j] + vx[(j + 2) % k]) / 2
                             + longint'($urandom_range(0, 1000)) - 500;
                        qy = (vy[j] + vy[(j + 2) % k]) / 2;
                    end
                end
            endcase
            if (qy > RANGE_Y) qy = RANGE_Y;
            if (qy < -RANGE_Y) qy = -RANGE_Y;
            send_item(bpip_pkg::FN_QUERY, qx, qy, rand_x(), rand_y());
        end
    endtask

    // band count beyond its range, widest and degenerate envelopes
    task automatic test_config_extremes;
        set_config(-RANGE_Y, RANGE_Y, 64);
        random_polygon(12, 10);
        set_config(-RANGE_Y, RANGE_Y, 0);
        random_polygon(8, 6);
        set_config(-RANGE_Y, RANGE_Y, 127);
        random_polygon(8, 6);
        set_config(RANGE_Y, RANGE_Y, 16);      // zero height
        random_polygon(8, 6);
        set_config(RANGE_Y, -RANGE_Y, 1);      // negative height
        random_polygon(8, 6);
        // bands of stored edges stay put after a config change
        set_config(-1000000, 1000000, 32);
        random_polygon(10, 0);
        set_config(-RANGE_Y, 0, 5);
        for (int i = 0; i < 8; i++) send_item(bpip_pkg::FN_QUERY, rand_x(), rand_y(), 0, 0);
    endtask

    // fill the store, then two loads too many, a query over the full store, a clear and a load
    task automatic test_full_store;
        set_config(-RANGE_Y, RANGE_Y, 64);
        send_item(bpip_pkg::FN_CLEAR, 0, 0, 0, 0);
        for (int i = 0; i < bpip_pkg::MAX_EDGES; i++)
            send_item(bpip_pkg::FN_LOAD, rand_x(), rand_y(), rand_x(), rand_y());
        send_item(bpip_pkg::FN_LOAD, 1, 2, 3, 4);
        send_item(bpip_pkg::FN_LOAD, -5, -6, -7, -8);
        send_item(bpip_pkg::FN_QUERY, rand_x(), rand_y(), 0, 0);
        send_item(bpip_pkg::FN_CLEAR, 0, 0, 0, 0);
        send_item(bpip_pkg::FN_LOAD, 10, 20, 30, 40);
    endtask

    // receiver holds off long while the sender keeps offering
    task automatic test_backpressure;
        drain();
        long_hold = 1'b1;
        random_polygon(6, 10);
        send_item(bpip_pkg::FN_QUERY, 0, 0, 0, 0);
        drain();
    endtask

    // random polygons, queries, noise and config changes
    task automatic test_random(int target);
        longint lo, hi;
        int     sent;
        int     k, q;
        sent = 0;
        while (sent < target) begin
            if ($urandom_range(0, 3) == 0) begin
                lo = rand_y();
                hi = rand_y();
                if (lo > hi && $urandom_range(0, 7) != 0) begin
                    lo = lo ^ hi; hi = lo ^ hi; lo = lo ^ hi;
                end
                set_config(lo, hi, ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127)
                                                                 : $urandom_range(1, 64));
            end
            if ($urandom_range(0, 7) == 0) begin
                // noise: unused codes and stray loads and queries
                repeat (4) send_item(FN_UNUSED, rand_x(), rand_y(), rand_x(), rand_y());
                send_item(bpip_pkg::FN_LOAD, rand_x(), rand_y(), rand_x(), rand_y());
                send_item(bpip_pkg::FN_QUERY, rand_x(), rand_y(), rand_x(), rand_y());
                sent += 6;
            end
            k = $urandom_range(3, 24);
            q = $urandom_range(4, 20);
            random_polygon(k, q);
            sent += 1 + k + q;
        end
    endtask

    initial begin
        repeat (2) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_square();
        test_config_extremes();
        test_full_store();
        test_backpressure();
        test_random(500);
        drain();
        quiet = 1'b1;
        test_random(120);
        drain();
        repeat (50) @(negedge aclk);
        if (errors == 0 && pending_answers.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
